@@ hdl/fdc_pkg.sv @@
package fdc_pkg;

  // geometry of the sector store
  localparam int DRIVES            = 2;
  localparam int SIDE_COUNT        = 2;
  localparam int TRACK_COUNT       = 80;
  localparam int SECTORS_PER_TRACK = 16;
  localparam int SECTOR_BYTES      = 256;

  localparam int STORE_SIZE = DRIVES * SIDE_COUNT * TRACK_COUNT * SECTORS_PER_TRACK
                              * SECTOR_BYTES;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int BYTE_POS_W = 9;

  // register offsets in the bus window
  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_CMD     = 3'd4;
  localparam logic [2:0] REG_TRACK   = 3'd5;
  localparam logic [2:0] REG_SECTOR  = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  // command codes, bits 7..4 of the command byte
  localparam logic [3:0] OP_RESTORE = 4'h0;
  localparam logic [3:0] OP_SEEK    = 4'h1;
  localparam logic [3:0] OP_STEP_IN = 4'h5;
  localparam logic [3:0] OP_READ    = 4'h8;
  localparam logic [3:0] OP_WRITE   = 4'hA;
  localparam logic [3:0] OP_FORCE   = 4'hD;

  // register values and status bits
  localparam logic [7:0] CTRL_RESET  = 8'hFF;
  localparam logic [7:0] STATUS_IDLE = 8'h80;
  localparam logic [7:0] STATUS_XFER = 8'h83;
  localparam logic [7:0] ST_BUSY     = 8'h01;
  localparam logic [7:0] ST_DRQ      = 8'h02;
  localparam logic [7:0] ST_TRK0     = 8'h04;

  // request to the sector store
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  // result of one bus transaction
  typedef struct packed {
    logic [7:0] rdata;
    logic       use_mem;
    logic       bad_command;
    logic       out_of_range;
    logic [1:0] modified_mask;
  } res_t;

  // linear store address of the current head position
  function automatic logic [ADDR_W-1:0] store_addr(
    input logic       drive,
    input logic       side,
    input logic [7:0] track,
    input logic [7:0] sector,
    input logic [BYTE_POS_W-1:0] byte_pos
  );
    int a;
    a = (((int'(drive) * SIDE_COUNT + int'(side)) * TRACK_COUNT + int'(track))
         * SECTORS_PER_TRACK + int'(sector)) * SECTOR_BYTES + int'(byte_pos[7:0]);
    return a[ADDR_W-1:0];
  endfunction

  // head position lies inside the store
  function automatic logic store_in_range(
    input logic       drive,
    input logic       side,
    input logic [7:0] track,
    input logic [7:0] sector
  );
    return (int'(drive) < DRIVES) && (int'(side) < SIDE_COUNT) &&
           (int'(track) < TRACK_COUNT) && (int'(sector) < SECTORS_PER_TRACK);
  endfunction

endpackage

@@ hdl/fdc_ram.sv @@
module fdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ hdl/fdc_core.sv @@
module fdc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic              req_type,
  input  logic [2:0]        reg_offset,
  input  logic [7:0]        wdata,
  input  logic [7:0]        mem_q,
  output fdc_pkg::mem_req_t mem_req,
  output fdc_pkg::res_t     res
);

  logic [7:0] control_r, control_nxt;
  logic [7:0] status_r, status_nxt;
  logic [7:0] track_r, track_nxt;
  logic [7:0] sector_r, sector_nxt;
  logic [7:0] data_r, data_nxt;
  logic       data_mem_r, data_mem_nxt;
  logic [7:0] command_r, command_nxt;
  logic [7:0] head_track_r, head_track_nxt;
  logic [7:0] head_sector_r, head_sector_nxt;
  logic [fdc_pkg::BYTE_POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic       drive_r, drive_nxt;
  logic       side_r, side_nxt;
  logic [1:0] modified_r, modified_nxt;

  logic [7:0] data_eff;
  logic [3:0] op;
  logic [3:0] cur_op;
  logic       in_range;
  logic [7:0] head_inc;
  logic [fdc_pkg::BYTE_POS_W-1:0] byte_pos_inc;
  logic       xfer_done;
  logic [7:0] st;

  // data register may still sit in the store read register
  assign data_eff     = data_mem_r ? mem_q : data_r;
  assign op           = wdata[7:4];
  assign cur_op       = command_r[7:4];
  assign in_range     = fdc_pkg::store_in_range(drive_r, side_r, head_track_r, head_sector_r);
  assign head_inc     = head_track_r + 8'd1;
  assign byte_pos_inc = byte_pos_r + fdc_pkg::BYTE_POS_W'(1);
  assign xfer_done    = byte_pos_inc >= fdc_pkg::BYTE_POS_W'(fdc_pkg::SECTOR_BYTES);

  // register update for one transaction
  always_comb begin
    control_nxt     = control_r;
    status_nxt      = status_r;
    track_nxt       = track_r;
    sector_nxt      = sector_r;
    data_nxt        = data_r;
    data_mem_nxt    = data_mem_r;
    command_nxt     = command_r;
    head_track_nxt  = head_track_r;
    head_sector_nxt = head_sector_r;
    byte_pos_nxt    = byte_pos_r;
    drive_nxt       = drive_r;
    side_nxt        = side_r;
    modified_nxt    = modified_r;
    st              = status_r;

    mem_req.rd    = 1'b0;
    mem_req.wr    = 1'b0;
    mem_req.addr  = fdc_pkg::store_addr(drive_r, side_r, head_track_r, head_sector_r,
                                        byte_pos_r);
    mem_req.wdata = wdata;

    res.rdata        = 8'h00;
    res.use_mem      = 1'b0;
    res.bad_command  = 1'b0;
    res.out_of_range = 1'b0;

    if (req_type) begin
      unique case (reg_offset)
        fdc_pkg::REG_CONTROL: begin
          control_nxt = wdata;
          if (wdata[5]) begin
            control_nxt = fdc_pkg::CTRL_RESET;
            status_nxt  = fdc_pkg::STATUS_IDLE;
          end
          if (wdata[1]) begin
            drive_nxt = 1'b1;
          end else if (wdata[0]) begin
            drive_nxt = 1'b0;
          end
          side_nxt = wdata[2];
        end
        fdc_pkg::REG_CMD: begin
          if (!status_r[0] || op == fdc_pkg::OP_FORCE) begin
            command_nxt = wdata;
            st = status_r | fdc_pkg::ST_BUSY;
            unique case (op)
              fdc_pkg::OP_RESTORE: begin
                track_nxt      = 8'h00;
                head_track_nxt = 8'h00;
                st = (st & ~fdc_pkg::ST_BUSY) | fdc_pkg::ST_TRK0;
              end
              fdc_pkg::OP_SEEK: begin
                track_nxt      = data_eff;
                head_track_nxt = data_eff;
                st = st & ~(fdc_pkg::ST_BUSY | fdc_pkg::ST_TRK0);
                if (data_eff == 8'h00) begin
                  st = st | fdc_pkg::ST_TRK0;
                end
              end
              fdc_pkg::OP_STEP_IN: begin
                track_nxt      = head_inc;
                head_track_nxt = head_inc;
                st = st & ~(fdc_pkg::ST_BUSY | fdc_pkg::ST_TRK0);
              end
              fdc_pkg::OP_READ, fdc_pkg::OP_WRITE: begin
                st              = fdc_pkg::STATUS_XFER;
                byte_pos_nxt    = '0;
                head_track_nxt  = track_r;
                head_sector_nxt = sector_r;
                if (op == fdc_pkg::OP_WRITE) begin
                  modified_nxt = modified_r | (2'b01 << drive_r);
                end
              end
              default: begin
                st = st & ~fdc_pkg::ST_BUSY;
                res.bad_command = 1'b1;
              end
            endcase
            status_nxt = st;
          end
        end
        fdc_pkg::REG_TRACK: track_nxt = wdata;
        fdc_pkg::REG_SECTOR: sector_nxt = wdata;
        fdc_pkg::REG_DATA: begin
          st           = status_r & ~fdc_pkg::ST_DRQ;
          data_nxt     = wdata;
          data_mem_nxt = 1'b0;
          if (cur_op == fdc_pkg::OP_WRITE) begin
            if (in_range) begin
              mem_req.wr = 1'b1;
            end else begin
              res.out_of_range = 1'b1;
            end
            byte_pos_nxt = byte_pos_inc;
            if (xfer_done) begin
              st          = fdc_pkg::STATUS_IDLE;
              command_nxt = 8'h00;
            end else begin
              st = st | fdc_pkg::ST_DRQ;
            end
          end
          status_nxt = st;
        end
        default: ;
      endcase
    end else begin
      unique case (reg_offset)
        fdc_pkg::REG_CONTROL: res.rdata = control_r;
        fdc_pkg::REG_CMD:     res.rdata = status_r;
        fdc_pkg::REG_TRACK:   res.rdata = track_r;
        fdc_pkg::REG_SECTOR:  res.rdata = sector_r;
        fdc_pkg::REG_DATA: begin
          res.rdata = data_eff;
          if (cur_op == fdc_pkg::OP_READ) begin
            if (in_range) begin
              mem_req.rd   = 1'b1;
              data_mem_nxt = 1'b1;
              res.use_mem  = 1'b1;
            end else begin
              data_nxt         = 8'h00;
              data_mem_nxt     = 1'b0;
              res.rdata        = 8'h00;
              res.out_of_range = 1'b1;
            end
            byte_pos_nxt = byte_pos_inc;
            if (xfer_done) begin
              status_nxt  = fdc_pkg::STATUS_IDLE;
              command_nxt = 8'h00;
            end
          end
        end
        default: ;
      endcase
    end

    res.modified_mask = modified_nxt;

    // nothing moves without a transaction
    if (!go) begin
      mem_req.rd = 1'b0;
      mem_req.wr = 1'b0;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r     <= fdc_pkg::CTRL_RESET;
      status_r      <= fdc_pkg::STATUS_IDLE;
      track_r       <= 8'h00;
      sector_r      <= 8'h00;
      data_r        <= 8'h00;
      data_mem_r    <= 1'b0;
      command_r     <= 8'h00;
      head_track_r  <= 8'h00;
      head_sector_r <= 8'h00;
      byte_pos_r    <= '0;
      drive_r       <= 1'b0;
      side_r        <= 1'b0;
      modified_r    <= 2'b00;
    end else if (go) begin
      control_r     <= control_nxt;
      status_r      <= status_nxt;
      track_r       <= track_nxt;
      sector_r      <= sector_nxt;
      data_r        <= data_nxt;
      data_mem_r    <= data_mem_nxt;
      command_r     <= command_nxt;
      head_track_r  <= head_track_nxt;
      head_sector_r <= head_sector_nxt;
      byte_pos_r    <= byte_pos_nxt;
      drive_r       <= drive_nxt;
      side_r        <= side_nxt;
      modified_r    <= modified_nxt;
    end
  end

endmodule

@@ hdl/floppy_controller_register_model_top.sv @@
// Floppy disc controller register model, host bus view.
// Input channel: one bus transaction per item (in_req_type, in_reg_offset,
// in_wdata), valid/ready handshake. Output channel: one result per
// transaction (out_rdata, out_bad_command, out_out_of_range,
// out_modified_mask), valid/ready handshake, in the same order.
// Order: a transaction taken into the input register moves on once the result
// register is free or out_ready is high; it then updates the controller
// registers and lands in the result register, raising out_valid. A data read of a
// sector returns the byte straight from the registered read port of the
// sector store, which is read as the transaction moves on.
// Throughput: one transaction per cycle while out_ready is high; the input
// and result registers form a two-stage pipe, and the sector store port is
// used at most once per transaction.
// Reset: controller registers return to their power-on values (control 0xFF,
// status 0x80, all others 0); the sector store is not cleared.
// Stall: while out_ready is low the result is held and the input register
// holds one more transaction; in_ready drops once both are full.
module floppy_controller_register_model_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [2:0] in_reg_offset,
  input  logic [7:0] in_wdata,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_rdata,
  output logic       out_bad_command,
  output logic       out_out_of_range,
  output logic [1:0] out_modified_mask
);

  logic       in_vld_r;
  logic       in_req_type_r;
  logic [2:0] in_reg_offset_r;
  logic [7:0] in_wdata_r;
  logic       out_vld_r;
  fdc_pkg::res_t     out_res_r;
  fdc_pkg::res_t     res;
  fdc_pkg::mem_req_t mem_req;
  logic [7:0] mem_q;
  logic       go;

  // pipe control
  assign go       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_req_type_r   <= in_req_type;
      in_reg_offset_r <= in_reg_offset;
      in_wdata_r      <= in_wdata;
    end
  end

  fdc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .req_type   (in_req_type_r),
    .reg_offset (in_reg_offset_r),
    .wdata      (in_wdata_r),
    .mem_q      (mem_q),
    .mem_req    (mem_req),
    .res        (res)
  );

  fdc_ram #(
    .WIDTH (8),
    .DEPTH (fdc_pkg::STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.wr),
    .re    (mem_req.rd),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (go) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_res_r <= res;
    end
  end

  // sector reads come from the store read register
  assign out_valid         = out_vld_r;
  assign out_rdata         = out_res_r.use_mem ? mem_q : out_res_r.rdata;
  assign out_bad_command   = out_res_r.bad_command;
  assign out_out_of_range  = out_res_r.out_of_range;
  assign out_modified_mask = out_res_r.modified_mask;

endmodule
